// ===== design/tssb_pkg.sv =====
// shared constants and types for the task slot scheduler
`default_nettype none
package tssb_pkg;
    localparam int MAX_SLOTS     = 32;
    localparam int MAX_BATCHES   = 8;
    localparam int PRIORITY_BITS = 32;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int BW = $clog2(MAX_BATCHES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_SUSP  = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_READY = 2'd1;
    localparam logic [1:0] B_RUN   = 2'd2;

    localparam logic [3:0] A_CREATE  = 4'd0;
    localparam logic [3:0] A_RNEXT   = 4'd1;
    localparam logic [3:0] A_RID     = 4'd2;
    localparam logic [3:0] A_YIELD   = 4'd3;
    localparam logic [3:0] A_FINISH  = 4'd4;
    localparam logic [3:0] A_BINIT   = 4'd5;
    localparam logic [3:0] A_BADD    = 4'd6;
    localparam logic [3:0] A_BRUN    = 4'd7;
    localparam logic [3:0] A_POP     = 4'd8;

    localparam logic [1:0] S_OK   = 2'd0;
    localparam logic [1:0] S_NONE = 2'd1;
    localparam logic [1:0] S_ERR  = 2'd2;

    typedef logic [PRIORITY_BITS-1:0] prio_t;

    // write port to the slot priority memory
    typedef struct packed {
        logic            en;
        logic [SW-1:0]   addr;
        prio_t           data;
    } prio_wr_t;
endpackage
`default_nettype wire

// ===== design/tssb_prio_ram.sv =====
// slot priority memory, one write and one registered read port
`default_nettype none
module tssb_prio_ram
    import tssb_pkg::*;
(
    input  wire logic           clk,
    input  wire prio_wr_t       wr,
    input  wire logic [SW-1:0]  raddr,
    output prio_t               rdata
);
    prio_t mem [MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/task_slot_scheduler_with_barriers_unit.sv =====
// task slot scheduler with join barriers, top level
// One transaction in, one result out. Most actions step through the phases that take the input,
// execute it, and refresh the status fields and raise the result, before the next possible accept.
// resume_next from the master first scans the effective slot count (slots_in_use, with 0 read
// as 1 and values above 32 read as 32) through the registered read port of the priority memory,
// one slot per cycle, and then drains the last read before it executes. The next input is taken
// once the result register is free.
`default_nettype none
module task_slot_scheduler_with_barriers_unit
    import tssb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  action,
    input  wire logic [31:0] priority_req,
    input  wire logic [4:0]  slot_id,
    input  wire logic [3:0]  batch_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [4:0]       result_slot,
    output logic [2:0]       result_batch,
    output logic [5:0]       running_slot,
    output logic [5:0]       active_count,
    output logic             free_slot_available,
    output logic             any_busy
);
    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_SCAN = 2'd1;
    localparam logic [1:0] P_EXEC = 2'd2;
    localparam logic [1:0] P_DONE = 2'd3;

    logic [5:0] siu_reg;
    logic [1:0] slot_state_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] slot_blocked_reg;
    logic [BW:0] slot_batch_reg [MAX_SLOTS];
    logic [1:0] batch_state_reg [MAX_BATCHES];
    logic [SW-1:0] batch_owner_reg [MAX_BATCHES];
    logic [MAX_SLOTS-1:0] batch_members_reg [MAX_BATCHES];
    logic [MAX_SLOTS-1:0] batch_finished_reg [MAX_BATCHES];
    logic [SW-1:0] fifo_reg [MAX_BATCHES];
    logic [BW-1:0] fifo_head_reg;
    logic [BW:0] fifo_count_reg;
    logic [SW:0] cur_reg;
    logic [SW:0] task_count_reg;

    logic [1:0] ph_reg;
    logic [3:0] act_reg;
    prio_t prio_reg;
    logic [SW-1:0] sid_reg;
    logic [3:0] bid_reg;
    logic [SW:0] scan_reg;
    logic [SW-1:0] rd_idx_reg;
    logic rd_pend_reg;
    logic best_v_reg;
    logic [SW-1:0] best_reg;
    prio_t best_p_reg;

    prio_wr_t pwr;
    logic [SW-1:0] raddr;
    prio_t rdata;

    tssb_prio_ram u_ram (.clk(clk), .wr(pwr), .raddr(raddr), .rdata(rdata));

    logic [SW:0] lim;
    always_comb
    begin
        if (siu_reg == 6'd0)
            lim = (SW+1)'(1);
        else if (siu_reg > 6'(MAX_SLOTS))
            lim = (SW+1)'(MAX_SLOTS);
        else
            lim = (SW+1)'(siu_reg);
    end

    // first idle slot below the limit
    logic idle_found;
    logic [SW-1:0] idle_idx;
    always_comb
    begin
        idle_found = 1'b0;
        idle_idx = '0;
        for (int i = MAX_SLOTS-1; i >= 0; i--)
        begin
            if ((SW+1)'(i) < lim && slot_state_reg[i] == ST_IDLE)
            begin
                idle_found = 1'b1;
                idle_idx = SW'(i);
            end
        end
    end

    logic busy_any;
    always_comb
    begin
        busy_any = ~cur_reg[SW];
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (slot_state_reg[i] != ST_IDLE)
                busy_any = 1'b1;
        end
    end

    logic idle_b_found;
    logic [BW-1:0] idle_b;
    always_comb
    begin
        idle_b_found = 1'b0;
        idle_b = '0;
        for (int i = MAX_BATCHES-1; i >= 0; i--)
        begin
            if (batch_state_reg[i] == B_IDLE)
            begin
                idle_b_found = 1'b1;
                idle_b = BW'(i);
            end
        end
    end

    assign in_stall = (ph_reg != P_IDLE) || (out_valid && out_stall);
    wire take = in_valid && !in_stall;

    // scan read address
    assign raddr = scan_reg[SW-1:0];

    wire [SW-1:0] cur = cur_reg[SW-1:0];
    wire master = cur_reg[SW];
    wire bvalid = bid_reg < 4'(MAX_BATCHES);
    wire [BW-1:0] bi = bid_reg[BW-1:0];
    wire [SW-1:0] rd_i = rd_idx_reg;
    wire rd_ok = rd_pend_reg && !slot_blocked_reg[rd_i]
        && (slot_state_reg[rd_i] == ST_READY || slot_state_reg[rd_i] == ST_SUSP);

    always_comb
    begin
        pwr.en = 1'b0;
        pwr.addr = idle_idx;
        pwr.data = prio_reg;
        if (ph_reg == P_EXEC && idle_found
            && (act_reg == A_CREATE || (act_reg == A_BADD && !master && bvalid
                && batch_state_reg[bi] == B_READY && batch_owner_reg[bi] == cur)))
            pwr.en = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg <= 6'd32;
            ph_reg <= P_IDLE;
            out_valid <= 1'b0;
            slot_blocked_reg <= '0;
            fifo_head_reg <= '0;
            fifo_count_reg <= '0;
            cur_reg <= (SW+1)'(MAX_SLOTS);
            task_count_reg <= '0;
            rd_pend_reg <= 1'b0;
            best_v_reg <= 1'b0;
            scan_reg <= '0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                slot_state_reg[i] <= ST_IDLE;
                slot_batch_reg[i] <= (BW+1)'(MAX_BATCHES);
            end
            for (int i = 0; i < MAX_BATCHES; i++)
            begin
                batch_state_reg[i] <= B_IDLE;
                batch_members_reg[i] <= '0;
                batch_finished_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                siu_reg <= cfg_wdata;
            if (ph_reg == P_DONE)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (ph_reg)
                P_IDLE:
                begin
                    if (take)
                    begin
                        act_reg <= action;
                        prio_reg <= priority_req[PRIORITY_BITS-1:0];
                        sid_reg <= slot_id;
                        bid_reg <= batch_id;
                        scan_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        best_v_reg <= 1'b0;
                        ph_reg <= (action == A_RNEXT && master) ? P_SCAN : P_EXEC;
                    end
                end
                P_SCAN:
                begin
                    if (scan_reg < lim)
                    begin
                        rd_idx_reg <= scan_reg[SW-1:0];
                        rd_pend_reg <= 1'b1;
                        scan_reg <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg)
                            ph_reg <= P_EXEC;
                    end
                    if (rd_ok && (!best_v_reg || rdata < best_p_reg))
                    begin
                        best_v_reg <= 1'b1;
                        best_reg <= rd_i;
                        best_p_reg <= rdata;
                    end
                end
                P_EXEC:
                begin
                    logic [1:0] st;
                    logic [SW-1:0] rs;
                    logic [BW-1:0] rb;
                    logic [BW:0] b;
                    st = S_OK;
                    rs = '0;
                    rb = '0;
                    b = '0;
                    case (act_reg)
                        A_CREATE, A_BADD:
                        begin
                            if (act_reg == A_BADD && (master || !bvalid
                                || batch_state_reg[bi] != B_READY || batch_owner_reg[bi] != cur))
                                st = S_ERR;
                            else if (!idle_found)
                                st = S_NONE;
                            else
                            begin
                                rs = idle_idx;
                                slot_state_reg[idle_idx] <= ST_READY;
                                slot_blocked_reg[idle_idx] <= 1'b0;
                                slot_batch_reg[idle_idx] <= bvalid ? {1'b0, bi}
                                    : (BW+1)'(MAX_BATCHES);
                                task_count_reg <= task_count_reg + 1'b1;
                                if (act_reg == A_BADD)
                                begin
                                    batch_members_reg[bi][idle_idx] <= 1'b1;
                                    batch_finished_reg[bi][idle_idx] <= 1'b0;
                                end
                            end
                        end
                        A_RNEXT:
                        begin
                            if (!master)
                                st = S_ERR;
                            else if (!best_v_reg)
                                st = S_NONE;
                            else
                            begin
                                rs = best_reg;
                                slot_state_reg[best_reg] <= ST_RUN;
                                cur_reg <= {1'b0, best_reg};
                            end
                        end
                        A_RID:
                        begin
                            b = slot_batch_reg[sid_reg];
                            if (!master || (SW+1)'(sid_reg) >= lim)
                                st = S_ERR;
                            else if (slot_state_reg[sid_reg] != ST_READY
                                && slot_state_reg[sid_reg] != ST_SUSP)
                                st = S_NONE;
                            else if (slot_blocked_reg[sid_reg] && (b[BW]
                                || batch_state_reg[b[BW-1:0]] != B_RUN
                                || (batch_members_reg[b[BW-1:0]]
                                    & ~batch_finished_reg[b[BW-1:0]]) != '0))
                                st = S_NONE;
                            else
                            begin
                                if (slot_blocked_reg[sid_reg])
                                begin
                                    batch_state_reg[b[BW-1:0]] <= B_IDLE;
                                    batch_members_reg[b[BW-1:0]] <= '0;
                                    batch_finished_reg[b[BW-1:0]] <= '0;
                                end
                                // owner of the released batch is the target itself
                                slot_blocked_reg[sid_reg] <= 1'b0;
                                if (slot_blocked_reg[sid_reg])
                                    slot_batch_reg[sid_reg] <= (BW+1)'(MAX_BATCHES);
                                rs = sid_reg;
                                slot_state_reg[sid_reg] <= ST_RUN;
                                cur_reg <= {1'b0, sid_reg};
                            end
                        end
                        A_YIELD:
                        begin
                            if (master)
                                st = S_ERR;
                            else
                            begin
                                slot_state_reg[cur] <= ST_SUSP;
                                cur_reg <= (SW+1)'(MAX_SLOTS);
                            end
                        end
                        A_FINISH:
                        begin
                            b = slot_batch_reg[cur];
                            if (master)
                                st = S_ERR;
                            else
                            begin
                                if (!b[BW])
                                begin
                                    if (batch_state_reg[b[BW-1:0]] != B_IDLE
                                        && batch_owner_reg[b[BW-1:0]] == cur
                                        && slot_blocked_reg[cur])
                                    begin
                                        batch_state_reg[b[BW-1:0]] <= B_IDLE;
                                        batch_members_reg[b[BW-1:0]] <= '0;
                                        batch_finished_reg[b[BW-1:0]] <= '0;
                                    end
                                    else if (batch_members_reg[b[BW-1:0]][cur])
                                    begin
                                        batch_finished_reg[b[BW-1:0]][cur] <= 1'b1;
                                        if (batch_state_reg[b[BW-1:0]] == B_RUN
                                            && (batch_members_reg[b[BW-1:0]]
                                                & ~batch_finished_reg[b[BW-1:0]]
                                                & ~(MAX_SLOTS'(1) << cur)) == '0
                                            && fifo_count_reg < (BW+1)'(MAX_BATCHES))
                                        begin
                                            fifo_reg[BW'(fifo_head_reg + fifo_count_reg[BW-1:0])]
                                                <= batch_owner_reg[b[BW-1:0]];
                                            fifo_count_reg <= fifo_count_reg + 1'b1;
                                        end
                                    end
                                end
                                slot_state_reg[cur] <= ST_IDLE;
                                slot_blocked_reg[cur] <= 1'b0;
                                slot_batch_reg[cur] <= (BW+1)'(MAX_BATCHES);
                                if (task_count_reg != '0)
                                    task_count_reg <= task_count_reg - 1'b1;
                                cur_reg <= (SW+1)'(MAX_SLOTS);
                            end
                        end
                        A_BINIT:
                        begin
                            b = slot_batch_reg[cur];
                            if (master || slot_blocked_reg[cur]
                                || (!b[BW] && batch_members_reg[b[BW-1:0]][cur]))
                                st = S_ERR;
                            else if (!idle_b_found)
                                st = S_NONE;
                            else
                            begin
                                batch_state_reg[idle_b] <= B_READY;
                                batch_owner_reg[idle_b] <= cur;
                                batch_members_reg[idle_b] <= '0;
                                batch_finished_reg[idle_b] <= '0;
                                slot_batch_reg[cur] <= {1'b0, idle_b};
                                slot_blocked_reg[cur] <= 1'b1;
                                rb = idle_b;
                            end
                        end
                        A_BRUN:
                        begin
                            if (master || !bvalid || batch_state_reg[bi] != B_READY
                                || batch_owner_reg[bi] != cur)
                                st = S_ERR;
                            else
                            begin
                                batch_state_reg[bi] <= B_RUN;
                                slot_state_reg[cur] <= ST_SUSP;
                                cur_reg <= (SW+1)'(MAX_SLOTS);
                                if ((batch_members_reg[bi] & ~batch_finished_reg[bi]) == '0
                                    && fifo_count_reg < (BW+1)'(MAX_BATCHES))
                                begin
                                    fifo_reg[BW'(fifo_head_reg + fifo_count_reg[BW-1:0])] <= cur;
                                    fifo_count_reg <= fifo_count_reg + 1'b1;
                                end
                            end
                        end
                        A_POP:
                        begin
                            if (!master)
                                st = S_ERR;
                            else if (fifo_count_reg == '0)
                                st = S_NONE;
                            else
                            begin
                                rs = fifo_reg[fifo_head_reg];
                                fifo_head_reg <= fifo_head_reg + 1'b1;
                                fifo_count_reg <= fifo_count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            st = S_ERR;
                        end
                    endcase
                    status <= st;
                    result_slot <= 5'(rs);
                    result_batch <= 3'(rb);
                    ph_reg <= P_DONE;
                end
                P_DONE:
                begin
                    // status refresh after state update, result raised here
                    running_slot <= 6'(cur_reg);
                    active_count <= 6'(task_count_reg);
                    free_slot_available <= idle_found;
                    any_busy <= busy_any;
                    ph_reg <= P_IDLE;
                end
                default:
                begin
                    ph_reg <= P_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/task_slot_scheduler_with_barriers_unit_tb.sv =====
// testbench for the task slot scheduler: scoreboard class with its own predictor, directed and random traffic
`timescale 1ns / 100ps
module task_slot_scheduler_with_barriers_unit_tb
    import tssb_pkg::*;
;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [3:0]  action;
        logic [31:0] prio;
        logic [4:0]  sid;
        logic [3:0]  bid;
    } sched_req_t;

    typedef struct {
        logic [1:0] status;
        logic [4:0] rslot;
        logic [2:0] rbatch;
        logic [5:0] running;
        logic [5:0] active;
        logic       free_av;
        logic       busy;
    } sched_resp_t;

    class sched_scoreboard;
        logic [1:0]  st[MAX_SLOTS];
        logic [31:0] prio[MAX_SLOTS];
        bit          blk[MAX_SLOTS];
        int          lnk[MAX_SLOTS];
        logic [1:0]  bst[MAX_BATCHES];
        int          bown[MAX_BATCHES];
        logic [31:0] bmem[MAX_BATCHES];
        logic [31:0] bfin[MAX_BATCHES];
        int          done_owners[$];
        int          running;
        int          tasks;
        int          slots_cfg;
        int          errors;
        sched_resp_t pending_resp[$];

        function new();
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                st[i] = ST_IDLE;
                prio[i] = '0;
                blk[i] = 0;
                lnk[i] = MAX_BATCHES;
            end
            for (int i = 0; i < MAX_BATCHES; i++)
            begin
                bst[i] = B_IDLE;
                bown[i] = 0;
                bmem[i] = '0;
                bfin[i] = '0;
            end
            running = MAX_SLOTS;
            tasks = 0;
            slots_cfg = 32;
            errors = 0;
        endfunction

        function int slot_limit();
            if (slots_cfg == 0)
                return 1;
            if (slots_cfg > MAX_SLOTS)
                return MAX_SLOTS;
            return slots_cfg;
        endfunction

        function int idle_slot();
            for (int i = 0; i < slot_limit(); i++)
                if (st[i] == ST_IDLE)
                    return i;
            return -1;
        endfunction

        function int alloc_slot(logic [31:0] p, int link);
            int s;
            s = idle_slot();
            if (s >= 0)
            begin
                st[s] = ST_READY;
                prio[s] = p;
                blk[s] = 0;
                lnk[s] = link;
                tasks++;
            end
            return s;
        endfunction

        function bit batch_complete(int b);
            return (bmem[b] & ~bfin[b]) == 0;
        endfunction

        function void push_owner(int o);
            if (done_owners.size() < MAX_BATCHES)
                done_owners = {done_owners, o};
        endfunction

        function void release_batch(int b);
            int o;
            o = bown[b];
            bst[b] = B_IDLE;
            bmem[b] = '0;
            bfin[b] = '0;
            blk[o] = 0;
            lnk[o] = MAX_BATCHES;
        endfunction

        function void note_request(sched_req_t r);
            sched_resp_t e;
            bit master;
            int cur, s, b, n;
            bit bvalid;
            master = running >= MAX_SLOTS;
            cur = running % MAX_SLOTS;
            bvalid = r.bid < MAX_BATCHES;
            n = slot_limit();
            e.status = S_OK;
            e.rslot = '0;
            e.rbatch = '0;
            case (r.action)
                A_CREATE:
                begin
                    s = alloc_slot(r.prio, bvalid ? int'(r.bid) : MAX_BATCHES);
                    if (s < 0)
                        e.status = S_NONE;
                    else
                        e.rslot = 5'(s);
                end
                A_RNEXT:
                begin
                    if (!master)
                        e.status = S_ERR;
                    else
                    begin
                        s = -1;
                        for (int i = 0; i < n; i++)
                        begin
                            if ((st[i] == ST_READY || st[i] == ST_SUSP) && !blk[i])
                                if (s < 0 || prio[i] < prio[s])
                                    s = i;
                        end
                        if (s < 0)
                            e.status = S_NONE;
                        else
                        begin
                            st[s] = ST_RUN;
                            running = s;
                            e.rslot = 5'(s);
                        end
                    end
                end
                A_RID:
                begin
                    s = r.sid;
                    if (!master || s >= n)
                        e.status = S_ERR;
                    else if (st[s] != ST_READY && st[s] != ST_SUSP)
                        e.status = S_NONE;
                    else
                    begin
                        b = lnk[s];
                        if (blk[s] && (b >= MAX_BATCHES || bst[b] != B_RUN || !batch_complete(b)))
                            e.status = S_NONE;
                        else
                        begin
                            if (blk[s])
                                release_batch(b);
                            st[s] = ST_RUN;
                            running = s;
                            e.rslot = 5'(s);
                        end
                    end
                end
                A_YIELD:
                begin
                    if (master)
                        e.status = S_ERR;
                    else
                    begin
                        st[cur] = ST_SUSP;
                        running = MAX_SLOTS;
                    end
                end
                A_FINISH:
                begin
                    if (master)
                        e.status = S_ERR;
                    else
                    begin
                        b = lnk[cur];
                        if (b < MAX_BATCHES)
                        begin
                            if (bst[b] != B_IDLE && bown[b] == cur && blk[cur])
                                release_batch(b);
                            else if (bmem[b][cur])
                            begin
                                bfin[b][cur] = 1'b1;
                                if (bst[b] == B_RUN && batch_complete(b))
                                    push_owner(bown[b]);
                            end
                        end
                        st[cur] = ST_IDLE;
                        blk[cur] = 0;
                        lnk[cur] = MAX_BATCHES;
                        if (tasks > 0)
                            tasks--;
                        running = MAX_SLOTS;
                    end
                end
                A_BINIT:
                begin
                    b = lnk[cur];
                    if (master || blk[cur] || (b < MAX_BATCHES && bmem[b][cur]))
                        e.status = S_ERR;
                    else
                    begin
                        e.status = S_NONE;
                        for (int i = 0; i < MAX_BATCHES; i++)
                        begin
                            if (e.status == S_NONE && bst[i] == B_IDLE)
                            begin
                                bst[i] = B_READY;
                                bown[i] = cur;
                                bmem[i] = '0;
                                bfin[i] = '0;
                                lnk[cur] = i;
                                blk[cur] = 1;
                                e.rbatch = 3'(i);
                                e.status = S_OK;
                            end
                        end
                    end
                end
                A_BADD:
                begin
                    if (master || !bvalid || bst[r.bid] != B_READY || bown[r.bid] != cur)
                        e.status = S_ERR;
                    else
                    begin
                        s = alloc_slot(r.prio, r.bid);
                        if (s < 0)
                            e.status = S_NONE;
                        else
                        begin
                            bmem[r.bid][s] = 1'b1;
                            bfin[r.bid][s] = 1'b0;
                            e.rslot = 5'(s);
                        end
                    end
                end
                A_BRUN:
                begin
                    if (master || !bvalid || bst[r.bid] != B_READY || bown[r.bid] != cur)
                        e.status = S_ERR;
                    else
                    begin
                        bst[r.bid] = B_RUN;
                        st[cur] = ST_SUSP;
                        running = MAX_SLOTS;
                        if (batch_complete(r.bid))
                            push_owner(cur);
                    end
                end
                A_POP:
                begin
                    if (!master)
                        e.status = S_ERR;
                    else if (done_owners.size() == 0)
                        e.status = S_NONE;
                    else
                    begin
                        e.rslot = 5'(done_owners[0]);
                        done_owners.delete(0);
                    end
                end
                default:
                    e.status = S_ERR;
            endcase
            e.running = 6'(running);
            e.active = 6'(tasks);
            e.free_av = idle_slot() >= 0;
            e.busy = running < MAX_SLOTS;
            for (int i = 0; i < MAX_SLOTS; i++)
                if (st[i] != ST_IDLE)
                    e.busy = 1;
            pending_resp = {pending_resp, e};
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(sched_resp_t a);
            sched_resp_t e;
            if (pending_resp.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending_resp[0];
            pending_resp.delete(0);
            compare_field("status", e.status, a.status);
            compare_field("result_slot", e.rslot, a.rslot);
            compare_field("result_batch", e.rbatch, a.rbatch);
            compare_field("running_slot", e.running, a.running);
            compare_field("active_count", e.active, a.active);
            compare_field("free_slot_available", e.free_av, a.free_av);
            compare_field("any_busy", e.busy, a.busy);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  action;
    logic [31:0] priority_req;
    logic [4:0]  slot_id;
    logic [3:0]  batch_id;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [4:0]  result_slot;
    logic [2:0]  result_batch;
    logic [5:0]  running_slot;
    logic [5:0]  active_count;
    logic        free_slot_available;
    logic        any_busy;

    sched_scoreboard sb;
    int burst_left;
    int hold_req;
    int hold_left;
    int stall_mode;
    int mode_left;
    int idle_cycles;

    task_slot_scheduler_with_barriers_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .action              (action),
        .priority_req        (priority_req),
        .slot_id             (slot_id),
        .batch_id            (batch_id),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .result_slot         (result_slot),
        .result_batch        (result_batch),
        .running_slot        (running_slot),
        .active_count        (active_count),
        .free_slot_available (free_slot_available),
        .any_busy            (any_busy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side
    always @(posedge clk)
    begin
        sched_resp_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            r.status = status;
            r.rslot = result_slot;
            r.rbatch = result_batch;
            r.running = running_slot;
            r.active = active_count;
            r.free_av = free_slot_available;
            r.busy = any_busy;
            sb.check_result(r);
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 3) == 0;
                    default: out_stall <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[task_slot_scheduler_with_barriers_unit] ERROR");
            $finish;
        end
    end

    task automatic send_req(sched_req_t r);
        int gap;
        action <= r.action;
        priority_req <= r.prio;
        slot_id <= r.sid;
        batch_id <= r.bid;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 25);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_op(logic [3:0] a, logic [31:0] p, logic [4:0] s, logic [3:0] b);
        sched_req_t r;
        r.action = a;
        r.prio = p;
        r.sid = s;
        r.bid = b;
        send_req(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_resp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slots_in_use(logic [5:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.slots_cfg = v;
    endtask

    function automatic logic [31:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    function automatic sched_req_t pick_req();
        sched_req_t r;
        int w, own;
        r.prio = pick_prio();
        r.sid = 5'($urandom_range(0, 4) == 0 ? $urandom_range(0, 31)
                                             : $urandom_range(0, sb.slot_limit() - 1));
        r.bid = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : MAX_BATCHES);
        w = $urandom_range(0, 99);
        if (sb.running >= MAX_SLOTS)
        begin
            if (w < 22)
                r.action = A_CREATE;
            else if (w < 52)
                r.action = A_RNEXT;
            else if (w < 70)
            begin
                r.action = A_RID;
                if (sb.done_owners.size() != 0 && $urandom_range(0, 1) == 0)
                    r.sid = 5'(sb.done_owners[0]);
            end
            else if (w < 88)
                r.action = A_POP;
            else
                r.action = 4'($urandom_range(0, 15));
        end
        else
        begin
            own = sb.lnk[sb.running];
            if (own < MAX_BATCHES && $urandom_range(0, 5) != 0)
                r.bid = 4'(own);
            if (w < 15)
                r.action = A_YIELD;
            else if (w < 35)
                r.action = A_FINISH;
            else if (w < 50)
                r.action = A_BINIT;
            else if (w < 72)
                r.action = A_BADD;
            else if (w < 88)
                r.action = A_BRUN;
            else if (w < 93)
                r.action = A_CREATE;
            else
                r.action = 4'($urandom_range(0, 15));
        end
        return r;
    endfunction

    initial
    begin
        logic [5:0] phase_cfg[8];
        sb = new();
        phase_cfg = '{6'd32, 6'd1, 6'd0, 6'd7, 6'd63, 6'd33, 6'd3, 6'd32};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        action = '0;
        priority_req = '0;
        slot_id = '0;
        batch_id = '0;
        burst_left = 1;
        hold_req = 0;
        hold_left = 0;
        mode_left = 0;
        stall_mode = 0;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(A_CREATE, 32'hFFFF_FFFF, 5'd0, 4'd8);
        send_op(A_CREATE, 32'h0000_0000, 5'd31, 4'd3);
        send_op(4'd15, 32'h0, 5'd0, 4'd0);
        send_op(A_YIELD, 32'h0, 5'd0, 4'd0);
        send_op(A_RNEXT, 32'h0, 5'd0, 4'd8);
        send_op(A_RNEXT, 32'h0, 5'd0, 4'd8);
        send_op(A_BINIT, 32'h0, 5'd0, 4'd8);
        send_op(A_BINIT, 32'h0, 5'd0, 4'd8);
        send_op(A_BADD, 32'd5, 5'd0, 4'd0);
        send_op(A_BADD, 32'd5, 5'd0, 4'd0);
        send_op(A_BADD, 32'd5, 5'd0, 4'd15);
        send_op(A_BRUN, 32'h0, 5'd0, 4'd0);
        send_op(A_RNEXT, 32'h0, 5'd0, 4'd8);
        send_op(A_FINISH, 32'h0, 5'd0, 4'd8);
        send_op(A_RID, 32'h0, 5'd1, 4'd8);
        send_op(A_RID, 32'h0, 5'd31, 4'd8);
        send_op(A_POP, 32'h0, 5'd0, 4'd8);
        send_op(A_RNEXT, 32'h0, 5'd0, 4'd8);
        send_op(A_FINISH, 32'h0, 5'd0, 4'd8);
        send_op(A_POP, 32'h0, 5'd0, 4'd8);
        send_op(A_RID, 32'h0, 5'd1, 4'd8);
        send_op(A_BINIT, 32'h0, 5'd0, 4'd8);
        send_op(A_BRUN, 32'h0, 5'd0, 4'd8);
        send_op(A_BRUN, 32'h0, 5'd0, 4'd0);
        send_op(4'd9, 32'h0, 5'd0, 4'd8);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_slots_in_use(phase_cfg[ph]);
            for (int k = 0; k < 80; k++)
            begin
                if (ph == 3 && k == 10)
                    hold_req = 400;
                send_req(pick_req());
            end
        end

        drain();
        if (sb.errors == 0)
            $display("[task_slot_scheduler_with_barriers_unit] OK");
        else
            $display("[task_slot_scheduler_with_barriers_unit] ERROR");
        $finish;
    end
endmodule
